// ----- hdl/sups_pkg.sv -----
// Shared types and codes for the sorted unique priority store.
`timescale 1ns / 1ps
package sups_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } sups_op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } sups_status_t;

  typedef struct packed {
    sups_op_t           func;
    logic signed [31:0] value;
  } sups_req_t;

  typedef struct packed {
    sups_status_t       status;
    logic [3:0]         position;
    logic [4:0]         count;
    logic               top_valid;
    logic signed [31:0] top_value;
  } sups_resp_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic ins;
    logic del;
  } sups_cell_ctrl_t;

endpackage

// ----- hdl/sups_stream_if.sv -----
// Valid/ready stream interface carrying one payload per beat.
`timescale 1ns / 1ps
interface sups_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sups_cell.sv -----
// One storage cell of the sorted chain, with its compare and scan flags.
`timescale 1ns / 1ps
module sups_cell (
  input  logic                     clk,
  input  sups_pkg::sups_cell_ctrl_t ctrl,
  input  logic signed [31:0]       value,
  input  logic                     occ,
  input  logic signed [31:0]       left_entry,
  input  logic                     left_gt,
  input  logic signed [31:0]       right_entry,
  input  logic                     right_sg,
  input  logic                     right_se,
  output logic signed [31:0]       entry,
  output logic                     gt,
  output logic                     sg,
  output logic                     se
);

  logic               is_gt;
  logic               is_eq;
  logic signed [31:0] entry_next;

  assign is_gt = occ && (entry > value);
  assign is_eq = occ && (entry == value);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && !gt) begin
      entry_next = left_gt ? value : left_entry;
    end else if (ctrl.del && !gt) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.load) begin
      gt <= is_gt;
      sg <= is_gt;
      se <= is_eq;
    end else if (ctrl.shift) begin
      sg <= right_sg;
      se <= right_se;
    end
  end

endmodule

// ----- hdl/sorted_unique_priority_store.sv -----
// Top level of the sorted unique priority store built from a chain of cells.
//
// The req channel carries one operation per beat: insert or delete of a signed
// 32-bit value. The resp channel returns exactly one beat per operation with
// the status, the position involved, the fill count and the current maximum.
// Values are kept in descending order, one per cell, so cell 0 holds the top.
// One operation is in flight at a time. Every cell compares its value with
// the request in the same cycle; the resulting flags then shift toward cell 0,
// one cell per cycle, until the first entry that is not greater than the
// request arrives. The chain then moves its entries one place, all in the
// same cycle. The scan stops at the position equal to the number of stored
// values greater than the request. A finished response waits in the output
// register while the next request is accepted and processed; only the
// response load waits on a stalled receiver. Reset empties the store at
// once; no clearing pass is needed.
`timescale 1ns / 1ps
module sorted_unique_priority_store #(
  parameter int CAPACITY = 16
) (
  input logic          clk,
  input logic          rst,
  sups_stream_if.sink   req,
  sups_stream_if.source resp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_COMPARE = 5'b00010,
    S_SCAN    = 5'b00100,
    S_APPLY   = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  state_t                   state;
  sups_pkg::sups_op_t       op;
  logic signed [31:0]       value;
  logic [CW-1:0]            count;
  logic [CW-1:0]            pos;
  logic                     found;
  sups_pkg::sups_status_t   status;
  sups_pkg::sups_cell_ctrl_t ctrl;

  logic signed [31:0] entry [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] sg;
  logic [CAPACITY-1:0] se;
  logic [CAPACITY-1:0] occ;

  logic               full;
  logic [CW+3:0]      pos_ext;
  logic [CW+4:0]      count_ext;

  assign full = (count == CW'(CAPACITY));
  assign req.ready = (state == S_IDLE);

  always_comb begin
    ctrl       = '0;
    ctrl.load  = (state == S_COMPARE);
    ctrl.shift = (state == S_SCAN) && sg[0];
    ctrl.ins   = (state == S_APPLY) && (op == sups_pkg::OP_INSERT) && !found && !full;
    ctrl.del   = (state == S_APPLY) && (op == sups_pkg::OP_DELETE) && found;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_entry;
    logic               left_gt;
    logic signed [31:0] right_entry;
    logic               right_sg;
    logic               right_se;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign left_entry = entry[0];
      assign left_gt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
      assign right_sg    = 1'b0;
      assign right_se    = 1'b0;
    end else begin : g_body
      assign right_entry = entry[i+1];
      assign right_sg    = sg[i+1];
      assign right_se    = se[i+1];
    end

    sups_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .value       (value),
      .occ         (occ[i]),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .right_sg    (right_sg),
      .right_se    (right_se),
      .entry       (entry[i]),
      .gt          (gt[i]),
      .sg          (sg[i]),
      .se          (se[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_COMPARE;
          end
        end
        S_COMPARE: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!sg[0]) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_RESP;
          if (ctrl.ins) begin
            count <= count + CW'(1);
          end else if (ctrl.del) begin
            count <= count - CW'(1);
          end
        end
        S_RESP: begin
          if (!resp.valid || resp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op    <= req.payload.func;
      value <= req.payload.value;
    end
    if (state == S_COMPARE) begin
      pos <= '0;
    end else if (ctrl.shift) begin
      pos <= pos + CW'(1);
    end else if (state == S_APPLY) begin
      if (!found && (op == sups_pkg::OP_DELETE || full)) begin
        pos <= '0;
      end
    end
    if (state == S_SCAN && !sg[0]) begin
      found <= se[0];
    end
    if (state == S_APPLY) begin
      if (op == sups_pkg::OP_INSERT) begin
        if (found) begin
          status <= sups_pkg::ST_DUPLICATE;
        end else if (full) begin
          status <= sups_pkg::ST_FULL;
        end else begin
          status <= sups_pkg::ST_INSERTED;
        end
      end else begin
        status <= found ? sups_pkg::ST_REMOVED : sups_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign pos_ext   = {4'b0, pos};
  assign count_ext = {5'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      resp.valid <= 1'b0;
    end else if (state == S_RESP && (!resp.valid || resp.ready)) begin
      resp.valid <= 1'b1;
    end else if (resp.ready) begin
      resp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!resp.valid || resp.ready)) begin
      resp.payload.status    <= status;
      resp.payload.position  <= pos_ext[3:0];
      resp.payload.count     <= count_ext[4:0];
      resp.payload.top_valid <= (count != '0);
      resp.payload.top_value <= (count != '0) ? entry[0] : 32'sd0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos <= count))
    else $error("scan ran past the occupied cells");

  a_one_move: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete moves at once");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_COMPARE))
    else $error("accepted request did not start a compare");

endmodule

// ----- tb/sorted_unique_priority_store_tb.sv -----
// Testbench for the sorted unique priority store: directed and random traffic checked per beat.
`timescale 1ns / 1ps
module sorted_unique_priority_store_tb;

  localparam int CAPACITY = 16;
  localparam int POOL_SIZE = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sups_stream_if #(.payload_t(sups_pkg::sups_req_t)) req ();
  sups_stream_if #(.payload_t(sups_pkg::sups_resp_t)) resp ();

  sorted_unique_priority_store #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .resp(resp)
  );

  logic signed [31:0]   held_vals [CAPACITY];
  int                   held_count = 0;
  sups_pkg::sups_resp_t pending_resps [$];
  logic signed [31:0]   value_pool [POOL_SIZE];
  int                   error_count = 0;
  int                   send_gap_pct = 0;
  int                   stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sups_pkg::sups_resp_t apply_to_store(sups_pkg::sups_op_t op,
                                                          logic signed [31:0] v);
    sups_pkg::sups_resp_t r;
    int                   hit;
    int                   slot;
    hit = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_vals[i] == v) hit = i;
    end
    r = '0;
    if (op == sups_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        r.status = sups_pkg::ST_DUPLICATE;
        r.position = hit[3:0];
      end else if (held_count >= CAPACITY) begin
        r.status = sups_pkg::ST_FULL;
      end else begin
        slot = held_count;
        while (slot > 0 && held_vals[slot - 1] < v) begin
          held_vals[slot] = held_vals[slot - 1];
          slot--;
        end
        held_vals[slot] = v;
        held_count++;
        r.status = sups_pkg::ST_INSERTED;
        r.position = slot[3:0];
      end
    end else if (hit >= 0) begin
      for (int i = hit; i < held_count - 1; i++) held_vals[i] = held_vals[i + 1];
      held_count--;
      r.status = sups_pkg::ST_REMOVED;
      r.position = hit[3:0];
    end else begin
      r.status = sups_pkg::ST_NOT_FOUND;
    end
    r.count = held_count[4:0];
    r.top_valid = (held_count > 0);
    r.top_value = (held_count > 0) ? held_vals[0] : '0;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value(sups_pkg::sups_op_t op);
    if (op == sups_pkg::OP_DELETE && held_count > 0 && $urandom_range(99) < 60)
      return held_vals[$urandom_range(held_count - 1)];
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic send_op(sups_pkg::sups_op_t op, logic signed [31:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= '{func: op, value: v};
    do @(posedge clk); while (!req.ready);
    pending_resps.push_back(apply_to_store(op, v));
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_cases();
    send_op(sups_pkg::OP_DELETE, 32'sd0);
    send_op(sups_pkg::OP_INSERT, 32'sd0);
    send_op(sups_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_op(sups_pkg::OP_INSERT, 32'sh8000_0000);
    send_op(sups_pkg::OP_INSERT, -32'sd1);
    send_op(sups_pkg::OP_INSERT, 32'sd0);
    send_op(sups_pkg::OP_INSERT, 32'sh8000_0000);
    send_op(sups_pkg::OP_DELETE, 32'sd5);
    send_op(sups_pkg::OP_DELETE, 32'sh7fff_ffff);
    send_op(sups_pkg::OP_DELETE, 32'sh8000_0000);
    send_op(sups_pkg::OP_DELETE, 32'sd0);
    send_op(sups_pkg::OP_DELETE, -32'sd1);
    send_op(sups_pkg::OP_INSERT, 32'sh8000_0000);
    send_op(sups_pkg::OP_DELETE, 32'sh8000_0000);
    drain_results();
  endtask

  task automatic test_full_store();
    logic signed [31:0] hi;
    int                 step;
    hi = $urandom_range(32'h7fff_ffff, 32'h4000_0000);
    step = $urandom_range(1000, 1);
    for (int k = 0; k < CAPACITY; k++) send_op(sups_pkg::OP_INSERT, hi - k * step);
    send_op(sups_pkg::OP_INSERT, hi - CAPACITY * step);
    send_op(sups_pkg::OP_INSERT, hi - (CAPACITY - 1) * step);
    send_op(sups_pkg::OP_DELETE, hi - (CAPACITY - 1) * step);
    send_op(sups_pkg::OP_INSERT, 32'sh8000_0000);
    while (held_count > 0)
      send_op(sups_pkg::OP_DELETE, held_vals[$urandom_range(held_count - 1)]);
    drain_results();
  endtask

  task automatic run_burst(int n_ops, int insert_pct);
    sups_pkg::sups_op_t op;
    repeat (n_ops) begin
      op = ($urandom_range(99) < insert_pct) ? sups_pkg::OP_INSERT : sups_pkg::OP_DELETE;
      send_op(op, pick_value(op));
    end
  endtask

  task automatic test_random_traffic(int gap_pct, int stall_in_pct);
    send_gap_pct = gap_pct;
    stall_pct = stall_in_pct;
    run_burst(60, 85);
    run_burst(60, 50);
    run_burst(55, 20);
    drain_results();
  endtask

  initial begin
    resp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      resp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_resp
    sups_pkg::sups_resp_t want;
    if (!rst && resp.valid && resp.ready) begin
      if (pending_resps.size() == 0) begin
        report_mismatch("result beat with nothing expected", resp.payload.top_value, '0);
      end else begin
        want = pending_resps.pop_front();
        if (resp.payload.status != want.status)
          report_mismatch("status", resp.payload.status, want.status);
        if (resp.payload.position != want.position)
          report_mismatch("position", resp.payload.position, want.position);
        if (resp.payload.count != want.count)
          report_mismatch("count", resp.payload.count, want.count);
        if (resp.payload.top_valid != want.top_valid)
          report_mismatch("top_valid", resp.payload.top_valid, want.top_valid);
        if (resp.payload.top_value != want.top_value)
          report_mismatch("top_value", resp.payload.top_value, want.top_value);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (resp.valid && resp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    req.valid <= 1'b0;
    req.payload <= '0;
    value_pool[0] = 32'sh7fff_ffff;
    value_pool[1] = 32'sh7fff_fffe;
    value_pool[2] = 32'sh8000_0000;
    value_pool[3] = 32'sh8000_0001;
    value_pool[4] = 32'sd0;
    value_pool[5] = 32'sd1;
    value_pool[6] = -32'sd1;
    for (int i = 7; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_full_store();
    test_random_traffic(0, 0);
    test_random_traffic(57, 0);
    test_random_traffic(0, 57);
    test_random_traffic(10, 10);
    repeat (CAPACITY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
